[hw/rtl/ttsp_pkg.sv]
// Shared types, constants and score helpers for the transposition table store/probe unit.
`default_nettype none

package ttsp_pkg;

    localparam int TABLE_ENTRIES = 65536;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TAG_W         = 64 - IDX_W;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    localparam logic signed [27:0] SCORE_MAX      = 28'sd134217727;
    localparam logic signed [27:0] SCORE_MIN      = -28'sd134217727;
    localparam logic signed [27:0] SCORE_RAW_MIN  = 28'sh8000000;
    localparam logic signed [27:0] MATE_THRESHOLD = 28'sd28976;

    typedef struct packed {
        logic                op;
        logic [63:0]         position_key;
        logic [6:0]          search_depth;
        logic [6:0]          search_ply;
        logic signed [27:0]  value_in;
        logic [1:0]          bound_kind;
        logic [31:0]         move_word;
        logic signed [27:0]  window_low;
        logic signed [27:0]  window_high;
    } request_t;

    typedef struct packed {
        logic                key_hit;
        logic                score_usable;
        logic signed [27:0]  value_out;
        logic [31:0]         move_out;
    } result_t;

    // clamp a grown score back to the field range
    function automatic logic signed [27:0] sat_score(input logic signed [28:0] v);
        logic signed [27:0] r;
        if (v > 29'sd134217727)
            r = SCORE_MAX;
        else if (v < -29'sd134217727)
            r = SCORE_MIN;
        else
            r = v[27:0];
        return r;
    endfunction

    // away = 1 moves a mate score away from zero by ply, away = 0 toward zero
    function automatic logic signed [27:0] mate_adjust(input logic signed [27:0] s,
                                                       input logic [6:0] ply,
                                                       input logic away);
        logic signed [28:0] sx;
        logic signed [28:0] px;
        logic signed [27:0] r;
        sx = {s[27], s};
        px = {22'd0, ply};
        if (s >= MATE_THRESHOLD)
            r = away ? sat_score(sx + px) : sat_score(sx - px);
        else if (s <= -MATE_THRESHOLD)
            r = away ? sat_score(sx - px) : sat_score(sx + px);
        else
            r = s;
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/transposition_table_store_probe_unit.sv]
// Direct-mapped transposition table, store and probe. A store replaces a slot that holds another
// key, or the same key at a depth no greater than its own. A store reads the slot when accepted
// and writes the new entry in ST_LOOK; a probe reads the slot, registers its fields in ST_LOOK,
// decides in ST_DECIDE and then strobes done from a register. A new request is taken only once
// the unit is back in idle (busy low). Reset: after rst_n releases, a clearing pass writes every
// one of the 65536 slots invalid, one per cycle; busy stays high until the pass ends.
`default_nettype none

module transposition_table_store_probe_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ttsp_pkg::request_t request,
    output logic                    done,
    output ttsp_pkg::result_t       result
);

    typedef struct packed {
        logic                           valid;
        logic [ttsp_pkg::TAG_W-1:0]     tag;
        logic [6:0]                     depth;
        logic [1:0]                     kind;
        logic signed [27:0]             score;
        logic [31:0]                    move;
    } slot_t;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOK   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [ttsp_pkg::IDX_W-1:0]     clr_idx_reg;
    logic                           accept;

    slot_t                          mem [ttsp_pkg::TABLE_ENTRIES];
    slot_t                          rd_data_reg;
    ttsp_pkg::request_t             req_reg;

    logic                           wr_en;
    logic [ttsp_pkg::IDX_W-1:0]     wr_addr;
    slot_t                          wr_data;

    logic                           tag_match;
    logic                           replace;
    logic signed [27:0]             value_clamped;

    logic                           hit_reg;
    logic                           deep_reg;
    logic [1:0]                     kind_reg;
    logic signed [27:0]             score_reg;
    logic [31:0]                    move_reg;

    logic                           usable;

    ttsp_pkg::result_t              result_reg;
    logic                           done_reg;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_idx_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                state_next = (req_reg.op == ttsp_pkg::OP_PROBE) ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            done_reg <= (state_reg == ST_DECIDE);
        end
    end

    // table lookup and store decision, valid while in ST_LOOK
    assign tag_match     = rd_data_reg.valid &&
                           (rd_data_reg.tag == req_reg.position_key[63:ttsp_pkg::IDX_W]);
    assign replace       = !tag_match || (req_reg.search_depth >= rd_data_reg.depth);
    assign value_clamped = (req_reg.value_in == ttsp_pkg::SCORE_RAW_MIN) ?
                           ttsp_pkg::SCORE_MIN : req_reg.value_in;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = req_reg.position_key[ttsp_pkg::IDX_W-1:0];
        wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
        end
        else if (state_reg == ST_LOOK && req_reg.op == ttsp_pkg::OP_STORE && replace)
        begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b1;
            wr_data.tag   = req_reg.position_key[63:ttsp_pkg::IDX_W];
            wr_data.depth = req_reg.search_depth;
            wr_data.kind  = req_reg.bound_kind;
            wr_data.score = ttsp_pkg::mate_adjust(value_clamped, req_reg.search_ply, 1'b1);
            wr_data.move  = req_reg.move_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= mem[request.position_key[ttsp_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= request;
        if (state_reg == ST_LOOK)
        begin
            hit_reg   <= tag_match;
            deep_reg  <= (rd_data_reg.depth >= req_reg.search_depth);
            kind_reg  <= rd_data_reg.kind;
            score_reg <= ttsp_pkg::mate_adjust(rd_data_reg.score, req_reg.search_ply, 1'b0);
            move_reg  <= rd_data_reg.move;
        end
    end

    // a lower bound closes the window when score >= beta, an upper one when alpha >= score
    always_comb
    begin
        usable = 1'b0;
        if (hit_reg && deep_reg)
        begin
            case (kind_reg)
                ttsp_pkg::BOUND_EXACT:
                    usable = 1'b1;
                ttsp_pkg::BOUND_LOWER:
                    usable = (score_reg >= req_reg.window_high) ||
                             (req_reg.window_low >= req_reg.window_high);
                ttsp_pkg::BOUND_UPPER:
                    usable = (req_reg.window_low >= score_reg) ||
                             (req_reg.window_low >= req_reg.window_high);
                default:
                    usable = (req_reg.window_low >= req_reg.window_high);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE)
        begin
            result_reg.key_hit      <= hit_reg;
            result_reg.score_usable <= usable;
            result_reg.value_out    <= usable ? score_reg : 28'sd0;
            result_reg.move_out     <= hit_reg ? move_reg : 32'd0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ttsp_checker.sv]
// Port-level checks for the transposition table store/probe unit, bound to its top level.
`default_nettype none

module ttsp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire ttsp_pkg::request_t request,
    input wire logic               done,
    input wire ttsp_pkg::result_t  result
);

    // a result beat lands as the unit returns to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy && $past(busy))
        else $error("result beat not at end of a busy item");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("two result beats in a row");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.op == ttsp_pkg::OP_STORE) |-> ##3 !done)
        else $error("store produced a result beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.key_hit) |->
            (!result.score_usable && result.value_out == 28'sd0 && result.move_out == 32'd0))
        else $error("miss carries payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.score_usable) |-> (result.value_out == 28'sd0))
        else $error("unusable score not zero");

endmodule

bind transposition_table_store_probe_unit ttsp_checker u_ttsp_checker (.*);

`default_nettype wire
